>>> rtl/bmm_pkg.sv
`default_nettype none

package bmm_pkg;

   // Build-time limits and register reset values.
   localparam int BMM_MAX_WIDTH  = 1024;
   localparam int BMM_MAX_HEIGHT = 4096;
   localparam int BMM_MIN_DIM    = 3;
   localparam int BMM_RST_WIDTH  = 640;
   localparam int BMM_RST_HEIGHT = 480;

   // Field and register widths fixed by the interface.
   localparam int BMM_CHAN_W       = 8;
   localparam int BMM_PIXEL_W      = 3 * BMM_CHAN_W;
   localparam int BMM_MASK_W       = 9;
   localparam int BMM_WIDTH_REG_W  = 11;
   localparam int BMM_HEIGHT_REG_W = 13;
   localparam int BMM_CSR_INDEX_W  = 2;
   localparam int BMM_CSR_DATA_W   = 13;

   localparam logic [BMM_MASK_W-1:0]  BMM_RST_MASK = 9'h1FF;
   // Bits kept after the window shifts by one: the new left and middle columns.
   localparam logic [BMM_MASK_W-1:0]  BMM_WIN_KEEP = 9'h0DB;
   localparam logic [BMM_PIXEL_W-1:0] BMM_WHITE    = 24'hFFFFFF;
   localparam logic [BMM_PIXEL_W-1:0] BMM_BLACK    = 24'h000000;

   typedef enum logic [BMM_CSR_INDEX_W-1:0] {
      CSR_WIDTH  = 2'd0,
      CSR_HEIGHT = 2'd1,
      CSR_MODE   = 2'd2,
      CSR_MASK   = 2'd3
   } bmm_csr_index_type;

   typedef enum logic {
      MODE_EROSION  = 1'b0,
      MODE_DILATION = 1'b1
   } bmm_mode_type;

   typedef struct packed {
      logic busy;
      logic done;
   } bmm_div_status_type;

   function automatic int unsigned bmm_clamp_dim(int unsigned value, int unsigned hi);
      int unsigned result;
      result = value;
      if (value < BMM_MIN_DIM) begin
         result = BMM_MIN_DIM;
      end else if (value > hi) begin
         result = hi;
      end
      return result;
   endfunction

endpackage

`default_nettype wire

>>> rtl/binary_morphology_3x3_core.sv
`default_nettype none

// Latency: a pixel's result leaves image_width + 1 requests after it entered, and the
// result of an accepted request is registered in stage 1 and then in the output register.
// Throughput: one request per cycle while req_stall is low, with the line and delay
// memories read on acceptance and the line memory written back in stage 1.
// Reset: control registers cleared, registers at 640 x 480, erosion, full mask; memories
// are not cleared. Requests stall after reset and after every register write while the
// area is recomputed, and also while the divider runs after a write of image_width.
module binary_morphology_3x3_core #(
   parameter int MAX_WIDTH = bmm_pkg::BMM_MAX_WIDTH,
   parameter int MAX_HEIGHT = bmm_pkg::BMM_MAX_HEIGHT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [bmm_pkg::BMM_CHAN_W-1:0]       req_red,
   input  wire logic [bmm_pkg::BMM_CHAN_W-1:0]       req_green,
   input  wire logic [bmm_pkg::BMM_CHAN_W-1:0]       req_blue,
   input  wire logic                                 req_drain,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic      [bmm_pkg::BMM_CHAN_W-1:0]       rsp_out_red,
   output logic      [bmm_pkg::BMM_CHAN_W-1:0]       rsp_out_green,
   output logic      [bmm_pkg::BMM_CHAN_W-1:0]       rsp_out_blue,
   output logic                                      rsp_frame_end,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [bmm_pkg::BMM_CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [bmm_pkg::BMM_CSR_DATA_W-1:0]   csr_data
);

   import bmm_pkg::*;

   // Derived sizes. The delay line holds one row plus one pixel.
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int W_W    = $clog2(MAX_WIDTH + 1);
   localparam int H_W    = $clog2(MAX_HEIGHT + 1);
   localparam int DEPTH  = MAX_WIDTH + 1;
   localparam int PTR_W  = $clog2(DEPTH);
   localparam int PEND_W = $clog2(MAX_WIDTH + 2);
   localparam int IDX_W  = $clog2(MAX_WIDTH * MAX_HEIGHT);
   localparam int WH_W   = W_W + H_W;
   localparam int AREA_W = (IDX_W + 1 > WH_W) ? IDX_W + 1 : WH_W;
   localparam int W_RST  = int'(bmm_clamp_dim(BMM_RST_WIDTH, MAX_WIDTH));
   localparam int H_RST  = int'(bmm_clamp_dim(BMM_RST_HEIGHT, MAX_HEIGHT));

   // ---------------------------------------------------------------------------------
   // Configuration. Width and height are held already clamped. After any write the
   // frame area is recomputed, and after a width write the output row and column are
   // rederived from the output index by the serial divider.
   // ---------------------------------------------------------------------------------
   logic [W_W-1:0]        w_ff, w_in;
   logic [H_W-1:0]        h_ff, h_in;
   bmm_mode_type          mode_ff, mode_in;
   logic [BMM_MASK_W-1:0] mask_ff, mask_in;
   logic [WH_W-1:0]       wh_ff;
   logic                  cfg_pending_ff, cfg_pending_in;
   logic                  width_dirty_ff, width_dirty_in;
   logic                  csr_we;
   logic                  cfg_busy;
   logic                  div_start;
   bmm_div_status_type    div_status;
   logic [IDX_W-1:0]      div_quotient;
   logic [W_W-1:0]        div_remainder;

   assign cfg_busy  = cfg_pending_ff | div_status.busy;
   assign csr_ready = !cfg_busy;
   assign csr_we    = csr_valid && csr_ready;
   assign div_start = cfg_pending_ff && width_dirty_ff;

   always_comb begin
      w_in           = w_ff;
      h_in           = h_ff;
      mode_in        = mode_ff;
      mask_in        = mask_ff;
      cfg_pending_in = csr_we;
      width_dirty_in = width_dirty_ff && !div_start;
      if (csr_we) begin
         unique case (bmm_csr_index_type'(csr_index))
            CSR_WIDTH: begin
               w_in = W_W'(bmm_clamp_dim(32'(csr_data[BMM_WIDTH_REG_W-1:0]), MAX_WIDTH));
               width_dirty_in = 1'b1;
            end
            CSR_HEIGHT: begin
               h_in = H_W'(bmm_clamp_dim(32'(csr_data[BMM_HEIGHT_REG_W-1:0]), MAX_HEIGHT));
            end
            CSR_MODE: begin
               mode_in = bmm_mode_type'(csr_data[0]);
            end
            CSR_MASK: begin
               mask_in = csr_data[BMM_MASK_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff           <= W_W'(W_RST);
         h_ff           <= H_W'(H_RST);
         mode_ff        <= MODE_EROSION;
         mask_ff        <= BMM_RST_MASK;
         // The area product is taken in the first cycle after reset.
         cfg_pending_ff <= 1'b1;
         width_dirty_ff <= 1'b0;
      end else begin
         w_ff           <= w_in;
         h_ff           <= h_in;
         mode_ff        <= mode_in;
         mask_ff        <= mask_in;
         cfg_pending_ff <= cfg_pending_in;
         width_dirty_ff <= width_dirty_in;
      end
      if (cfg_pending_ff) begin
         wh_ff <= WH_W'(w_ff) * WH_W'(h_ff);
      end
   end

   // ---------------------------------------------------------------------------------
   // Stage 0: acceptance. The column and delay counters advance here, the line memory
   // is read at the input column and the delay memory at the pixel now due out.
   // ---------------------------------------------------------------------------------
   logic              s1_valid_ff;
   logic              s1_adv;
   logic              req_accept;
   logic              s0_pixel;
   logic              s0_emit;
   logic [COL_W-1:0]  in_col_ff, in_col_in;
   logic [PEND_W-1:0] pending_ff, pending_in;
   logic [PTR_W-1:0]  delay_pos_ff, delay_pos_in;
   logic [PTR_W-1:0]  delay_rd_addr;
   logic              s0_fg;

   assign req_stall  = cfg_busy | (s1_valid_ff & !s1_adv);
   assign req_accept = req_valid && !req_stall;
   assign s0_pixel   = !req_drain;
   assign s0_fg      = |{req_red, req_green, req_blue};

   always_comb begin
      if (s0_pixel) begin
         s0_emit = 32'(pending_ff) >= 32'(w_ff) + 1;
      end else begin
         s0_emit = pending_ff != '0;
      end

      // Oldest pending entry, modulo the delay depth.
      if (32'(delay_pos_ff) >= 32'(pending_ff)) begin
         delay_rd_addr = PTR_W'(32'(delay_pos_ff) - 32'(pending_ff));
      end else begin
         delay_rd_addr = PTR_W'(32'(delay_pos_ff) + DEPTH - 32'(pending_ff));
      end

      in_col_in    = in_col_ff;
      pending_in   = pending_ff;
      delay_pos_in = delay_pos_ff;
      if (req_accept) begin
         if (s0_pixel) begin
            if (32'(in_col_ff) + 1 >= 32'(w_ff)) begin
               in_col_in = '0;
            end else begin
               in_col_in = in_col_ff + COL_W'(1);
            end
            if (!s0_emit) begin
               pending_in = pending_ff + PEND_W'(1);
            end
            if (delay_pos_ff == PTR_W'(DEPTH - 1)) begin
               delay_pos_in = '0;
            end else begin
               delay_pos_in = delay_pos_ff + PTR_W'(1);
            end
         end else if (s0_emit) begin
            pending_in = pending_ff - PEND_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff    <= '0;
         pending_ff   <= '0;
         delay_pos_ff <= '0;
      end else begin
         in_col_ff    <= in_col_in;
         pending_ff   <= pending_in;
         delay_pos_ff <= delay_pos_in;
      end
   end

   // Line memory: bit 1 is the row above the previous one, bit 0 the previous row.
   logic             line_re;
   logic             line_we;
   logic [1:0]       line_rd_data;
   logic [1:0]       line_wr_data;
   logic [COL_W-1:0] s1_col_ff;

   assign line_re = req_accept && s0_pixel;

   bmm_ram #(
      .DATA_W(2),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock  (clock),
      .rd_en  (line_re),
      .rd_addr(in_col_ff),
      .rd_data(line_rd_data),
      .wr_en  (line_we),
      .wr_addr(s1_col_ff),
      .wr_data(line_wr_data)
   );

   // Delay memory: the pixel is stored on acceptance and read back one row and one
   // pixel later, or earlier by drain requests at the end of the stream.
   logic                   delay_re;
   logic                   delay_we;
   logic [BMM_PIXEL_W-1:0] delay_rd_data;

   assign delay_re = req_accept && s0_emit;
   assign delay_we = req_accept && s0_pixel;

   bmm_ram #(
      .DATA_W(BMM_PIXEL_W),
      .DEPTH (DEPTH)
   ) u_delay_ram (
      .clock  (clock),
      .rd_en  (delay_re),
      .rd_addr(delay_rd_addr),
      .rd_data(delay_rd_data),
      .wr_en  (delay_we),
      .wr_addr(delay_pos_ff),
      .wr_data({req_red, req_green, req_blue})
   );

   // ---------------------------------------------------------------------------------
   // Stage 1: the window shifts in the column just read, the line memory is written
   // back, and the pixel due out is judged against the mask. Drain requests leave the
   // window as it stands.
   // ---------------------------------------------------------------------------------
   logic                   s1_pixel_ff;
   logic                   s1_emit_ff;
   logic                   s1_fg_ff;
   logic [BMM_MASK_W-1:0]  window_ff;
   logic [BMM_MASK_W-1:0]  win_shift;
   logic [BMM_MASK_W-1:0]  win_cur;
   logic [BMM_MASK_W-1:0]  hit;
   logic                   interior;
   logic                   frame_last;
   logic [BMM_PIXEL_W-1:0] result;
   logic                   out_free;
   logic [IDX_W-1:0]       out_index_ff, out_index_in;
   logic [IDX_W-1:0]       out_row_ff, out_row_in;
   logic [COL_W-1:0]       out_col_ff, out_col_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [BMM_PIXEL_W-1:0] rsp_pixel_ff;
   logic                   rsp_frame_end_ff;

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign s1_adv       = s1_valid_ff && (out_free || !s1_emit_ff);
   assign line_we      = s1_adv && s1_pixel_ff;
   assign line_wr_data = {line_rd_data[0], s1_fg_ff};

   always_comb begin
      win_shift = ((window_ff >> 1) & BMM_WIN_KEEP)
                | (BMM_MASK_W'(line_rd_data[1]) << 2)
                | (BMM_MASK_W'(line_rd_data[0]) << 5)
                | (BMM_MASK_W'(s1_fg_ff) << 8);
      win_cur = s1_pixel_ff ? win_shift : window_ff;
      hit     = win_cur & mask_ff;

      interior = (out_row_ff != '0) && (32'(out_row_ff) < 32'(h_ff) - 1)
              && (out_col_ff != '0) && (32'(out_col_ff) < 32'(w_ff) - 1);

      result = delay_rd_data;
      if (interior) begin
         if (mode_ff == MODE_EROSION) begin
            result = (hit == mask_ff) ? delay_rd_data : BMM_BLACK;
         end else begin
            result = (hit != '0) ? BMM_WHITE : BMM_BLACK;
         end
      end

      frame_last = AREA_W'(out_index_ff) + AREA_W'(1) >= AREA_W'(wh_ff);

      out_index_in = out_index_ff;
      out_row_in   = out_row_ff;
      out_col_in   = out_col_ff;
      if (div_status.done) begin
         out_row_in = div_quotient;
         out_col_in = COL_W'(div_remainder);
      end else if (s1_adv && s1_emit_ff) begin
         if (frame_last) begin
            out_index_in = '0;
            out_row_in   = '0;
            out_col_in   = '0;
         end else begin
            out_index_in = out_index_ff + IDX_W'(1);
            if (32'(out_col_ff) + 1 >= 32'(w_ff)) begin
               out_col_in = '0;
               out_row_in = out_row_ff + IDX_W'(1);
            end else begin
               out_col_in = out_col_ff + COL_W'(1);
            end
         end
      end

      if (s1_adv && s1_emit_ff) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         window_ff    <= '0;
         out_index_ff <= '0;
         out_row_ff   <= '0;
         out_col_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv && s1_pixel_ff) begin
            window_ff <= win_shift;
         end
         out_index_ff <= out_index_in;
         out_row_ff   <= out_row_in;
         out_col_ff   <= out_col_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_accept) begin
         s1_pixel_ff <= s0_pixel;
         s1_emit_ff  <= s0_emit;
         s1_fg_ff    <= s0_fg;
         s1_col_ff   <= in_col_ff;
      end
      if (s1_adv && s1_emit_ff) begin
         rsp_pixel_ff     <= result;
         rsp_frame_end_ff <= frame_last;
      end
   end

   bmm_divider #(
      .DIVIDEND_W(IDX_W),
      .DIVISOR_W (W_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (out_index_ff),
      .divisor  (w_ff),
      .status   (div_status),
      .quotient (div_quotient),
      .remainder(div_remainder)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_red   = rsp_pixel_ff[2*BMM_CHAN_W +: BMM_CHAN_W];
   assign rsp_out_green = rsp_pixel_ff[BMM_CHAN_W +: BMM_CHAN_W];
   assign rsp_out_blue  = rsp_pixel_ff[0 +: BMM_CHAN_W];
   assign rsp_frame_end = rsp_frame_end_ff;

   // The write-back of one column never meets a read of the same column.
   a_line_no_collision : assert property (@(posedge clock) disable iff (reset)
      (line_we && line_re) |-> (s1_col_ff != in_col_ff))
      else $error("line memory read and write-back hit the same column");

   // No request enters while the area or the output position is being recomputed.
   a_no_accept_cfg : assert property (@(posedge clock) disable iff (reset)
      cfg_busy |-> !req_accept)
      else $error("request accepted during configuration update");

   // The pending count never exceeds the delay depth.
   a_pending_range : assert property (@(posedge clock) disable iff (reset)
      32'(pending_ff) <= DEPTH)
      else $error("pending count beyond delay depth");

   // A result is only formed when the output register can take it.
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_pixel_ff)))
      else $error("stalled result was overwritten");

endmodule

`default_nettype wire

>>> rtl/bmm_ram.sv
`default_nettype none

module bmm_ram #(
   parameter int DATA_W = 1,
   parameter int DEPTH = bmm_pkg::BMM_MAX_WIDTH,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Read-first: a read and a write to the same entry return the old data.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/bmm_divider.sv
`default_nettype none

module bmm_divider #(
   parameter int DIVIDEND_W = 22,
   parameter int DIVISOR_W = 11
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [DIVIDEND_W-1:0]     dividend,
   input  wire logic [DIVISOR_W-1:0]      divisor,
   output bmm_pkg::bmm_div_status_type    status,
   output logic      [DIVIDEND_W-1:0]     quotient,
   output logic      [DIVISOR_W-1:0]      remainder
);

   import bmm_pkg::*;

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [DIVIDEND_W-1:0] quot_ff, quot_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  divisor_ff, divisor_in;
   logic [DIVISOR_W:0]    partial;
   logic [DIVISOR_W:0]    diff;

   // One quotient bit per cycle, restoring form.
   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      partial    = {rem_ff, quot_ff[DIVIDEND_W-1]};
      diff       = partial - {1'b0, divisor_ff};
      if (start) begin
         busy_in    = 1'b1;
         count_in   = CNT_W'(DIVIDEND_W);
         quot_in    = dividend;
         rem_in     = '0;
         divisor_in = divisor;
      end else if (busy_ff) begin
         if (partial >= {1'b0, divisor_ff}) begin
            rem_in  = diff[DIVISOR_W-1:0];
            quot_in = {quot_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in  = partial[DIVISOR_W-1:0];
            quot_in = {quot_ff[DIVIDEND_W-2:0], 1'b0};
         end
         count_in = count_ff - CNT_W'(1);
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quot_ff;
   assign remainder   = rem_ff;

   a_start_busy : assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff)
      else $error("divider did not start");

   a_done_idle : assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff && $past(busy_ff))
      else $error("divider done without a finished run");

   a_rem_range : assert property (@(posedge clock) disable iff (reset)
      done_ff |-> rem_ff < divisor_ff)
      else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

>>> dv/testbench.sv
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import bmm_pkg::*;

   localparam int HISTORY_DEPTH = BMM_MAX_WIDTH + 1;

   // One request as offered on the input channel, and one processed pixel as it
   // is expected on the result channel.
   typedef struct packed {
      logic [BMM_CHAN_W-1:0] red;
      logic [BMM_CHAN_W-1:0] green;
      logic [BMM_CHAN_W-1:0] blue;
      logic                  drain;
   } morph_request_t;

   typedef struct packed {
      logic [BMM_CHAN_W-1:0] red;
      logic [BMM_CHAN_W-1:0] green;
      logic [BMM_CHAN_W-1:0] blue;
      logic                  frame_end;
   } morph_result_t;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [BMM_CHAN_W-1:0]      req_red = '0;
   logic [BMM_CHAN_W-1:0]      req_green = '0;
   logic [BMM_CHAN_W-1:0]      req_blue = '0;
   logic                       req_drain = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [BMM_CHAN_W-1:0]      rsp_out_red;
   logic [BMM_CHAN_W-1:0]      rsp_out_green;
   logic [BMM_CHAN_W-1:0]      rsp_out_blue;
   logic                       rsp_frame_end;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [BMM_CSR_INDEX_W-1:0] csr_index = '0;
   logic [BMM_CSR_DATA_W-1:0]  csr_data = '0;

   binary_morphology_3x3_core DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_red       (req_red),
      .req_green     (req_green),
      .req_blue      (req_blue),
      .req_drain     (req_drain),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue),
      .rsp_frame_end (rsp_frame_end),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   // 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Requests waiting to be offered, and processed pixels still to arrive.
   morph_request_t pixel_queue[$];
   morph_result_t  expected_pixels[$];

   // Handshake flags raised at the rising edge and consumed at the falling edge.
   bit          req_taken;
   bit          rsp_taken;
   int unsigned send_gap;
   int unsigned rsp_gap;
   int unsigned send_idle_max;
   int unsigned recv_idle_max;
   int unsigned hold_left;
   int unsigned holds_done;

   int unsigned mismatches;
   int unsigned results_seen;
   int unsigned requests_taken;
   int unsigned drains_taken;
   int unsigned register_writes;
   int unsigned random_items;

   // Shadow copy of the register file, starting from the reset values.
   logic [BMM_WIDTH_REG_W-1:0]  cfg_width = BMM_RST_WIDTH;
   logic [BMM_HEIGHT_REG_W-1:0] cfg_height = BMM_RST_HEIGHT;
   bmm_mode_type                cfg_mode = MODE_EROSION;
   logic [BMM_MASK_W-1:0]       cfg_mask = BMM_RST_MASK;

   // Shadow copy of the datapath: two rows of foreground bits, the pixel delay
   // line, the 3x3 foreground neighbourhood and the input and output positions.
   bit                      fg_row_above[BMM_MAX_WIDTH];
   bit                      fg_row_prev[BMM_MAX_WIDTH];
   logic [BMM_PIXEL_W-1:0]  history[HISTORY_DEPTH];
   logic [BMM_MASK_W-1:0]   nbhd = '0;
   int unsigned             next_col;
   int unsigned             out_pos;
   int unsigned             in_flight;
   int unsigned             hist_wr;

   // The block works on the register values clamped to what it can hold.
   function automatic int unsigned dim_used(int unsigned value, int unsigned hi);
      if (value < BMM_MIN_DIM) begin
         return BMM_MIN_DIM;
      end
      return (value > hi) ? hi : value;
   endfunction

   function automatic void report_mismatch(string msg);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%0t: mismatch: %s", $realtime, msg);
      end
   endfunction

   function automatic void apply_register(bmm_csr_index_type idx,
                                          logic [BMM_CSR_DATA_W-1:0] value);
      register_writes++;
      case (idx)
         CSR_WIDTH: begin
            cfg_width = value[BMM_WIDTH_REG_W-1:0];
         end
         CSR_HEIGHT: begin
            cfg_height = value[BMM_HEIGHT_REG_W-1:0];
         end
         CSR_MODE: begin
            cfg_mode = bmm_mode_type'(value[0]);
         end
         CSR_MASK: begin
            cfg_mask = value[BMM_MASK_W-1:0];
         end
         default: begin
         end
      endcase
   endfunction

   // Advances the shadow datapath by one accepted request and queues the pixel
   // that it pushes out, if any. A pixel enters the delay line and leaves
   // width + 1 requests later; a drain only pushes out what is waiting and
   // leaves the neighbourhood as it stands.
   task automatic predict_request(input morph_request_t rq);
      int unsigned            w;
      int unsigned            h;
      int unsigned            col;
      int unsigned            orow;
      int unsigned            ocol;
      bit                     fg;
      bit                     top;
      bit                     mid;
      bit                     emit;
      logic [BMM_PIXEL_W-1:0] pix;
      logic [BMM_PIXEL_W-1:0] res;
      logic [BMM_MASK_W-1:0]  hit;
      morph_result_t          want;
      w = dim_used(cfg_width, BMM_MAX_WIDTH);
      h = dim_used(cfg_height, BMM_MAX_HEIGHT);
      pix = BMM_BLACK;
      if (!rq.drain) begin
         fg = (rq.red | rq.green | rq.blue) != 0;
         col = next_col % BMM_MAX_WIDTH;
         top = fg_row_above[col];
         mid = fg_row_prev[col];
         fg_row_above[col] = mid;
         fg_row_prev[col] = fg;
         // Shift the neighbourhood one column left; the new right column holds
         // the bits of two rows up, one row up and this row.
         nbhd = ((nbhd >> 1) & BMM_WIN_KEEP) | {fg, 2'b00, mid, 2'b00, top, 2'b00};
         next_col = (next_col + 1 >= w) ? 0 : next_col + 1;
         emit = in_flight >= w + 1;
         if (emit) begin
            pix = history[(hist_wr + HISTORY_DEPTH - in_flight) % HISTORY_DEPTH];
         end else begin
            in_flight++;
         end
         history[hist_wr] = {rq.red, rq.green, rq.blue};
         hist_wr = (hist_wr + 1) % HISTORY_DEPTH;
      end else begin
         emit = in_flight > 0;
         if (emit) begin
            pix = history[(hist_wr + HISTORY_DEPTH - in_flight) % HISTORY_DEPTH];
            in_flight--;
         end
      end
      if (emit) begin
         orow = out_pos / w;
         ocol = out_pos % w;
         res = pix;
         if (orow != 0 && orow < h - 1 && ocol != 0 && ocol < w - 1) begin
            hit = nbhd & cfg_mask;
            if (cfg_mode == MODE_EROSION) begin
               res = (hit == cfg_mask) ? pix : BMM_BLACK;
            end else begin
               res = (hit != 0) ? BMM_WHITE : BMM_BLACK;
            end
         end
         want.red = res[23:16];
         want.green = res[15:8];
         want.blue = res[7:0];
         want.frame_end = out_pos + 1 >= w * h;
         out_pos = want.frame_end ? 0 : out_pos + 1;
         expected_pixels.push_back(want);
      end
   endtask

   // Everything is sampled at the rising edge, before the block's own updates
   // of that edge take effect: register writes feed the shadow registers,
   // results are checked against the oldest expectation, and accepted requests
   // drive the prediction.
   always @(posedge clock) begin
      morph_result_t got;
      morph_result_t want;
      morph_request_t rq;
      req_taken = 1'b0;
      rsp_taken = 1'b0;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            apply_register(bmm_csr_index_type'(csr_index), csr_data);
         end
         if (rsp_valid && !rsp_stall) begin
            rsp_taken = 1'b1;
            results_seen++;
            got = {rsp_out_red, rsp_out_green, rsp_out_blue, rsp_frame_end};
            if (expected_pixels.size() == 0) begin
               report_mismatch($sformatf("result %0d (rgb %h end %b) with none expected",
                                         results_seen, got[24:1], got.frame_end));
            end else begin
               want = expected_pixels.pop_front();
               if (got.red !== want.red || got.green !== want.green ||
                   got.blue !== want.blue || got.frame_end !== want.frame_end) begin
                  report_mismatch($sformatf(
                     "result %0d: expected r %h g %h b %h end %b, got r %h g %h b %h end %b",
                     results_seen, want.red, want.green, want.blue, want.frame_end,
                     got.red, got.green, got.blue, got.frame_end));
               end
            end
         end
         if (req_valid && !req_stall) begin
            req_taken = 1'b1;
            requests_taken++;
            rq = {req_red, req_green, req_blue, req_drain};
            if (rq.drain) begin
               drains_taken++;
            end
            predict_request(rq);
         end
      end
   end

   // Request driver: holds a request until it is taken, then waits a randomly
   // drawn number of cycles before offering the next one from the queue.
   always @(negedge clock) begin
      morph_request_t nxt;
      logic           valid_next;
      valid_next = req_valid && !req_taken;
      if (!reset && !valid_next) begin
         if (send_gap != 0) begin
            send_gap--;
         end else if (pixel_queue.size() != 0) begin
            nxt = pixel_queue.pop_front();
            req_red <= nxt.red;
            req_green <= nxt.green;
            req_blue <= nxt.blue;
            req_drain <= nxt.drain;
            valid_next = 1'b1;
            send_gap = $urandom_range(0, send_idle_max);
         end
      end
      req_valid <= valid_next;
   end

   // Result receiver: stalls for a randomly drawn number of cycles after each
   // result. Twice in the run it holds off for a long stretch so that the
   // block backs up and stalls its input while requests keep coming.
   always @(negedge clock) begin
      logic stall_now;
      if (!reset) begin
         if (rsp_taken) begin
            rsp_gap = $urandom_range(0, recv_idle_max);
         end
         if ((results_seen == 1500 && holds_done == 0) ||
             (results_seen == 4000 && holds_done == 1)) begin
            hold_left = 400;
            holds_done++;
         end
      end
      stall_now = (hold_left != 0) || (rsp_gap != 0);
      if (hold_left != 0) begin
         hold_left--;
      end else if (rsp_gap != 0) begin
         rsp_gap--;
      end
      rsp_stall <= stall_now;
   end

   function automatic logic [BMM_PIXEL_W-1:0] random_pixel(int unsigned density);
      logic [BMM_PIXEL_W-1:0] px;
      px = BMM_BLACK;
      if ($urandom_range(0, 99) < density) begin
         case ($urandom_range(0, 3))
            0: begin
               px = BMM_WHITE;
            end
            1: begin
               px = 24'h1 << $urandom_range(0, BMM_PIXEL_W - 1);
            end
            default: begin
               px = $urandom_range(1, 24'hFFFFFF);
            end
         endcase
      end
      return px;
   endfunction

   task automatic queue_pixel(logic [BMM_PIXEL_W-1:0] px);
      pixel_queue.push_back({px, 1'b0});
   endtask

   // Drain requests carry random colour bits, which the block must ignore.
   task automatic queue_drain();
      logic [BMM_PIXEL_W-1:0] junk;
      junk = $urandom_range(0, 24'hFFFFFF);
      pixel_queue.push_back({junk, 1'b1});
   endtask

   // Waits until every request has gone in and every expected result has
   // come out, then lets the block's pipeline run empty, since a drain with
   // nothing waiting leaves no result to wait for.
   task automatic settle();
      while (pixel_queue.size() != 0 || req_valid || expected_pixels.size() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
   endtask

   task automatic write_register(bmm_csr_index_type idx, int unsigned value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value[BMM_CSR_DATA_W-1:0];
      do begin
         @(posedge clock);
      end while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(int unsigned wreg, int unsigned hreg, bmm_mode_type md,
                            int unsigned msk);
      write_register(CSR_WIDTH, wreg);
      write_register(CSR_HEIGHT, hreg);
      write_register(CSR_MODE, md);
      write_register(CSR_MASK, msk);
   endtask

   // Pushes out every pixel still in the delay line, sometimes adding a drain
   // when nothing is left so that the block must stay silent.
   task automatic flush_tail();
      settle();
      repeat (in_flight) queue_drain();
      if ($urandom_range(0, 4) == 0) begin
         queue_drain();
      end
      settle();
   endtask

   // Queues a run of pixels with an occasional drain mixed in; a drain in the
   // middle of a frame judges the next waiting pixel on the neighbourhood as
   // it stands.
   task automatic queue_stream(int unsigned count, int unsigned density,
                               int unsigned drain_pct);
      repeat (count) begin
         if ($urandom_range(0, 99) < drain_pct) begin
            queue_drain();
         end
         queue_pixel(random_pixel(density));
      end
   endtask

   task automatic random_phase(int unsigned phase);
      int unsigned  pick;
      int unsigned  wreg;
      int unsigned  hreg;
      int unsigned  w;
      int unsigned  h;
      int unsigned  total;
      int unsigned  msk;
      bmm_mode_type md;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         wreg = $urandom_range(0, 2);
      end else if (pick == 1) begin
         wreg = $urandom_range(11, 40);
      end else begin
         wreg = $urandom_range(3, 10);
      end
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         hreg = $urandom_range(0, 2);
      end else if (pick < 3) begin
         hreg = $urandom_range(8, 12);
      end else begin
         hreg = $urandom_range(3, 7);
      end
      md = bmm_mode_type'($urandom_range(0, 1));
      pick = $urandom_range(0, 19);
      msk = (pick < 3) ? 0 : (pick < 6) ? 9'h1FF : $urandom_range(1, 510);
      // The first two phases pin down the empty structuring element in both modes.
      if (phase < 2) begin
         md = (phase == 0) ? MODE_DILATION : MODE_EROSION;
         msk = 0;
      end
      send_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 9;
      recv_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 9;
      configure(wreg, hreg, md, msk);
      w = dim_used(wreg, BMM_MAX_WIDTH);
      h = dim_used(hreg, BMM_MAX_HEIGHT);
      // Whole frames back to back, sometimes followed by a frame cut short.
      total = $urandom_range(1, 3) * w * h;
      if ($urandom_range(0, 9) < 3) begin
         total += $urandom_range(1, w * h - 1);
      end
      queue_stream(total, $urandom_range(20, 95), 4);
      random_items += total;
      flush_tail();
   endtask

   initial begin
      logic [BMM_PIXEL_W-1:0] directed_px[18];
      int unsigned            phase;
      directed_px = '{24'hFFFFFF, 24'h010000, 24'h000100,
                      24'h000001, 24'h000080, 24'h800000,
                      24'h008000, 24'h7F7F7F, 24'hFEFEFE,
                      24'h000000, 24'hFFFFFF, 24'h000001,
                      24'h010101, 24'hFFFFFF, 24'hFFFFFF,
                      24'hAAAAAA, 24'h555555, 24'hFFFFFF};
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // A drain straight after reset has nothing to push out.
      queue_drain();
      settle();

      // The widest frame first, at full rate: it writes every column of both
      // line buffers, and the first long hold-off of the receiver falls
      // inside it. The width register goes to its top value.
      configure(2047, 3, MODE_EROSION, 9'h1FF);
      queue_stream(BMM_MAX_WIDTH * 3, 60, 0);
      flush_tail();

      // Directed part: the smallest frame, with both size registers at zero.
      // The first frame is all foreground, so its centre pixel survives
      // erosion; the second follows back to back with a black corner, so its
      // centre turns black. The colours walk the channel extremes.
      send_idle_max = 3;
      recv_idle_max = 3;
      configure(0, 0, MODE_EROSION, 9'h1FF);
      foreach (directed_px[i]) begin
         queue_pixel(directed_px[i]);
      end
      flush_tail();

      // The tallest frame is started and then cut short by lowering the
      // height in mid-frame, so rows past the new size wrap and pass through.
      send_idle_max = 9;
      recv_idle_max = 9;
      configure(3, 8191, MODE_DILATION, 9'h0BA);
      queue_stream(3 * 20, 50, 0);
      settle();
      write_register(CSR_HEIGHT, 4);
      queue_stream(3 * 4 * 2, 50, 0);
      flush_tail();

      // The width is lowered in mid-frame while more pixels are waiting than
      // the new width would hold; those leave one for one as new ones enter.
      configure(12, 5, MODE_EROSION, 9'h1FF);
      queue_stream(12 * 5 + 30, 80, 0);
      settle();
      write_register(CSR_WIDTH, 7);
      queue_stream(7 * 5 * 2, 80, 0);
      flush_tail();

      // Random settings, mostly small frames with random content.
      phase = 0;
      while (random_items < 1600) begin
         random_phase(phase);
         phase++;
      end

      settle();
      repeat (20) @(posedge clock);
      foreach (expected_pixels[i]) begin
         report_mismatch($sformatf("expected result r %h g %h b %h end %b never came",
                                   expected_pixels[i].red, expected_pixels[i].green,
                                   expected_pixels[i].blue, expected_pixels[i].frame_end));
      end
      $display("Run: %0d requests (%0d drains), %0d results checked, %0d register writes, %0d mismatches.",
               requests_taken, drains_taken, results_seen, register_writes, mismatches);
      $display("Covered erosion and dilation, empty to full masks, widths 3 to 1024, heights 3 to 4096, %0d random settings.",
               phase);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // A hang anywhere above ends the run here.
   initial begin
      #10_000_000;
      $display("Timed out with %0d results still expected.", expected_pixels.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule

`default_nettype wire
